/* design/rle_sprite_rgb555_expander_unit_macros.svh */
// ----------------------------------------------------------------------------
// rle sprite expander assertion macros
// concurrent check wrappers, removed for synthesis
// ----------------------------------------------------------------------------
`ifndef RLE_SPRITE_RGB555_EXPANDER_UNIT_MACROS_SVH
`define RLE_SPRITE_RGB555_EXPANDER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// check sampled on clk, ignored while reset is asserted
`define RSE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check sampled on clk, also during reset
`define RSE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RSE_ASSERT(label, prop, msg)
`define RSE_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

/* design/rse_pkg.sv */
// ----------------------------------------------------------------------------
// rse_pkg
// types, phase codes and pixel expansion for the rle sprite expander
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rse_pkg;

  // marker control byte that announces a transparent skip count
  localparam logic [7:0] SKIP_MARK  = 8'd255;
  localparam logic [7:0] ALPHA_FULL = 8'hFF;

  // input transaction
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  // result transaction
  typedef struct packed {
    logic [31:0] out_word;
    logic        record_end;
  } out_item_t;

  // parser result toward the output register
  typedef struct packed {
    logic      emit;
    out_item_t item;
  } parse_res_t;

  // parser phases, one-hot
  typedef enum logic [3:0] {
    PH_CONTROL = 4'b0001,
    PH_SKIP    = 4'b0010,
    PH_LOW     = 4'b0100,
    PH_HIGH    = 4'b1000
  } phase_t;

  // rgb555 to opaque argb8888, each channel padded with its own top bits
  function automatic logic [31:0] expand_pixel(input logic [15:0] p);
    return {ALPHA_FULL,
            p[14:10], p[14:12],
            p[9:5],   p[9:7],
            p[4:0],   p[4:2]};
  endfunction

endpackage

/* design/rse_parser.sv */
// ----------------------------------------------------------------------------
// rse_parser
// record phase tracking and word generation for one byte per cycle while fire is high
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rle_sprite_rgb555_expander_unit_macros.svh"

module rse_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  rse_pkg::in_item_t item,
  output rse_pkg::parse_res_t res
);

  rse_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]      pixels_left_r, pixels_left_nxt;
  logic [7:0]      pixel_low_r, pixel_low_nxt;
  logic [7:0]      pixels_dec;

  assign pixels_dec = pixels_left_r - 8'd1;

  // next state and result for the byte at the head of the pipe
  always_comb begin
    phase_nxt           = phase_r;
    pixels_left_nxt     = pixels_left_r;
    pixel_low_nxt       = pixel_low_r;
    res.emit            = 1'b0;
    res.item.out_word   = {24'd0, item.data_byte};
    res.item.record_end = item.last_byte;
    unique case (phase_r)
      rse_pkg::PH_CONTROL: begin
        res.emit = 1'b1;
        if (item.data_byte == rse_pkg::SKIP_MARK) begin
          phase_nxt = rse_pkg::PH_SKIP;
        end else if (item.data_byte != 8'd0) begin
          pixels_left_nxt = item.data_byte;
          phase_nxt       = rse_pkg::PH_LOW;
        end
      end
      rse_pkg::PH_SKIP: begin
        res.emit  = 1'b1;
        phase_nxt = rse_pkg::PH_CONTROL;
      end
      rse_pkg::PH_LOW: begin
        pixel_low_nxt = item.data_byte;
        phase_nxt     = rse_pkg::PH_HIGH;
      end
      rse_pkg::PH_HIGH: begin
        res.emit          = 1'b1;
        res.item.out_word = rse_pkg::expand_pixel({item.data_byte, pixel_low_r});
        pixels_left_nxt   = pixels_dec;
        phase_nxt         = (pixels_dec != 8'd0) ? rse_pkg::PH_LOW : rse_pkg::PH_CONTROL;
      end
      default: begin
        phase_nxt = rse_pkg::PH_CONTROL;
      end
    endcase
    // record end drops whatever run is left over
    if (item.last_byte) begin
      phase_nxt       = rse_pkg::PH_CONTROL;
      pixels_left_nxt = 8'd0;
      pixel_low_nxt   = 8'd0;
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= rse_pkg::PH_CONTROL;
      pixels_left_r <= 8'd0;
      pixel_low_r   <= 8'd0;
    end else if (fire) begin
      phase_r       <= phase_nxt;
      pixels_left_r <= pixels_left_nxt;
      pixel_low_r   <= pixel_low_nxt;
    end
  end

  // a pixel phase always owes at least one pixel
  `RSE_ASSERT(a_run_nonzero,
    (phase_r == rse_pkg::PH_LOW || phase_r == rse_pkg::PH_HIGH) |-> (pixels_left_r != 8'd0),
    "pixel phase with empty run")
  // the last byte of a record returns the parser to the control phase
  `RSE_ASSERT(a_last_resets,
    (fire && item.last_byte) |=> (phase_r == rse_pkg::PH_CONTROL && pixels_left_r == 8'd0),
    "parser not back in control phase after last byte")
  // a skip count is followed by a control byte
  `RSE_ASSERT(a_skip_then_control,
    (fire && phase_r == rse_pkg::PH_SKIP) |=> (phase_r == rse_pkg::PH_CONTROL),
    "skip count not followed by control phase")

endmodule

/* design/rle_sprite_rgb555_expander_unit.sv */
// ----------------------------------------------------------------------------
// rle_sprite_rgb555_expander_unit
// rle sprite record to argb8888 word stream expander
// ----------------------------------------------------------------------------
// usage:
//   in_item carries one byte of a compressed sprite record and its last-byte
//   flag; out_item carries one 32-bit word and its record-end flag. both
//   channels move a transaction on a rising edge with valid high and stall
//   low.
//   control bytes and skip counts come out unchanged, each two-byte rgb555
//   pixel comes out as one opaque argb8888 word, and a pixel low byte
//   produces no word.
//   each byte is held in the input register, then passes through the parser
//   into the output register.
//   throughput is one byte per cycle while out_stall is low; the parser
//   phase update is the only loop.
//   reset clears the valid flags of both pipeline registers and returns the
//   parser to the control phase; the first byte after reset is a control byte.
//   while out_stall holds a word, in_stall rises once the input register is
//   full; no transaction is lost or repeated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rle_sprite_rgb555_expander_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rse_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output rse_pkg::out_item_t out_item
);

  logic                in_valid_r;
  rse_pkg::in_item_t   in_item_r;
  logic                out_valid_r;
  rse_pkg::out_item_t  out_item_r;
  logic                advance;
  logic                fire;
  rse_pkg::parse_res_t res;

  // output register free or draining this cycle
  assign advance  = !out_valid_r || !out_stall;
  assign fire     = in_valid_r && advance;
  assign in_stall = in_valid_r && !advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r <= in_item;
    end
  end

  rse_parser u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (in_item_r),
    .res   (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= fire && res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= res.item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
